// File: hdl/voxel_visible_face_culling_unit_defines.svh
// ----------------------------------------------------------------------------
// Voxel face culling assertion macros
// Shared property wrappers for the port-level checker. Each macro samples
// on the rising edge of i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VOXEL_VISIBLE_FACE_CULLING_UNIT_DEFINES_SVH
`define VOXEL_VISIBLE_FACE_CULLING_UNIT_DEFINES_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds too.
`define VVFC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent holds
// in the cycle after it.
`define VVFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/vvfc_pkg.sv
// ----------------------------------------------------------------------------
// Voxel face culling package
// Shared widths, register indexes, state and row-select types, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package vvfc_pkg;

    // Default grid edge length in voxels.
    localparam int MAX_DIM_DEFAULT = 64;

    // Field widths.
    localparam int COORD_W     = 6;
    localparam int SIZE_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;
    localparam int FACE_W      = 6;

    // World extent after reset.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // Face bit positions in the mask.
    localparam int FACE_PX = 0;
    localparam int FACE_MX = 1;
    localparam int FACE_PY = 2;
    localparam int FACE_MY = 3;
    localparam int FACE_PZ = 4;
    localparam int FACE_MZ = 5;

    // Query row sequence: the center row, then the four neighbor rows.
    localparam int            STEP_W    = 3;
    localparam logic [STEP_W-1:0] NUM_ROWS = 3'd5;

    typedef enum logic [2:0] {
        ROW_CENTER = 3'd0,
        ROW_YP     = 3'd1,
        ROW_YM     = 3'd2,
        ROW_ZP     = 3'd3,
        ROW_ZM     = 3'd4
    } t_row_sel;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_READ,
        ST_WR_WRITE,
        ST_Q_CHECK,
        ST_Q_READ,
        ST_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic     clear_we;
        logic     load_item;
        logic     rd_issue;
        t_row_sel rd_sel;
        logic     consume;
        logic     wr_back;
        logic     load_result;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clear_done;
        logic write_ok;
        logic out_of_range;
        logic out_free;
    } t_dp_status;

endpackage

// File: hdl/voxel_visible_face_culling_unit.sv
// ----------------------------------------------------------------------------
// Voxel visible face culling unit
// Keeps a one-bit occupancy grid and answers visible-face queries.
//
// Input stream (s_*): s_tuser is the action (0 write, 1 query); s_tdata
// carries voxel_x, voxel_y, voxel_z and filled. A write sets or clears one
// voxel and returns nothing. A query returns one result on the output
// stream (m_*): m_tdata carries the face mask and voxel_solid, m_tuser
// flags a query outside the configured world size.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index (0 size_x,
// 1 size_y, 2 size_z) and i_cfg_data; always ready, write only while idle.
// Sequencing: a write reads and writes back one grid row. A query fills its
// result register after five row reads (center, +y, -y, +z, -z) through the
// single memory port; an out-of-range query skips the row reads.
// After reset a clearing pass writes MAX_DIM*MAX_DIM rows with s_tready low.
// A result waits in the output register while m_tready is low; the next item
// is still accepted, and its result is held until the register frees.
// ----------------------------------------------------------------------------
module voxel_visible_face_culling_unit
    import vvfc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SIZE_W-1:0]      i_cfg_data,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // voxel_x[5:0], voxel_y[11:6],
                                             // voxel_z[17:12], filled[18], zero pad
    input  logic                   s_tuser,  // action (0 write, 1 query)
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // face_mask[5:0], voxel_solid[6], zero pad
    output logic                   m_tuser   // out_of_range
);

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic [FACE_W-1:0] face_mask;
    logic              voxel_solid;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    vvfc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .i_query  (s_tuser),
        .o_ready  (s_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Grid memory and face logic.
    vvfc_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_voxel_x      (s_tdata[5:0]),
        .i_voxel_y      (s_tdata[11:6]),
        .i_voxel_z      (s_tdata[17:12]),
        .i_filled       (s_tdata[18]),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_m_valid      (m_tvalid),
        .i_m_ready      (m_tready),
        .o_face_mask    (face_mask),
        .o_voxel_solid  (voxel_solid),
        .o_out_of_range (m_tuser)
    );

    // Pack the result word.
    assign m_tdata = {1'b0, voxel_solid, face_mask};

endmodule

// File: hdl/vvfc_ctrl.sv
// ----------------------------------------------------------------------------
// Voxel face culling controller
// Sequences the reset clearing pass, occupancy writes (read-modify-write of
// one grid row) and queries (five row reads), and hands results to the
// output register.
// ----------------------------------------------------------------------------
module vvfc_ctrl
    import vvfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_query,
    output logic       o_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    // State and step registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) n_state = i_query ? ST_Q_CHECK : ST_WR_READ;
            end
            ST_WR_READ: begin
                n_state = i_status.write_ok ? ST_WR_WRITE : ST_IDLE;
            end
            ST_WR_WRITE: begin
                n_state = ST_IDLE;
            end
            ST_Q_CHECK: begin
                n_step = '0;
                n_state = i_status.out_of_range ? ST_DONE : ST_Q_READ;
            end
            ST_Q_READ: begin
                if (r_step == NUM_ROWS) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Output decode: commands to the datapath and the input ready.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_cmd.rd_sel = ROW_CENTER;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_we = 1'b1;
            end
            ST_IDLE: begin
                o_ready         = 1'b1;
                o_cmd.load_item = i_valid;
            end
            ST_WR_READ: begin
                o_cmd.rd_issue = i_status.write_ok;
            end
            ST_WR_WRITE: begin
                o_cmd.wr_back = 1'b1;
            end
            ST_Q_CHECK: begin
            end
            ST_Q_READ: begin
                o_cmd.rd_issue = (r_step < NUM_ROWS);
                o_cmd.consume  = (r_step != '0);
                case (r_step)
                    3'd1:    o_cmd.rd_sel = ROW_YP;
                    3'd2:    o_cmd.rd_sel = ROW_YM;
                    3'd3:    o_cmd.rd_sel = ROW_ZP;
                    3'd4:    o_cmd.rd_sel = ROW_ZM;
                    default: o_cmd.rd_sel = ROW_CENTER;
                endcase
            end
            ST_DONE: begin
                o_cmd.load_result = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hdl/vvfc_datapath.sv
// ----------------------------------------------------------------------------
// Voxel face culling datapath
// Holds the size registers, the latched item, the occupancy memory (one row
// of voxels along x per word), the face accumulation and the output register.
// ----------------------------------------------------------------------------
module vvfc_datapath
    import vvfc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SIZE_W-1:0]      i_cfg_data,
    // Input item fields
    input  logic [COORD_W-1:0]     i_voxel_x,
    input  logic [COORD_W-1:0]     i_voxel_y,
    input  logic [COORD_W-1:0]     i_voxel_z,
    input  logic                   i_filled,
    // Controller link
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    // Result channel
    output logic                   o_m_valid,
    input  logic                   i_m_ready,
    output logic [FACE_W-1:0]      o_face_mask,
    output logic                   o_voxel_solid,
    output logic                   o_out_of_range
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAX_DIM + 1);
    localparam int CMP_W = ((SW > SIZE_W) ? SW : SIZE_W) + 1;

    // Configuration registers.
    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SIZE_X: r_size_x <= i_cfg_data;
                REG_SIZE_Y: r_size_y <= i_cfg_data;
                REG_SIZE_Z: r_size_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Item registers.
    logic [COORD_W-1:0] r_x, r_y, r_z;
    logic               r_fill;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_x    <= i_voxel_x;
            r_y    <= i_voxel_y;
            r_z    <= i_voxel_z;
            r_fill <= i_filled;
        end
    end

    // Effective extents saturate at the grid edge length.
    logic [CMP_W-1:0] size_x_e, size_y_e, size_z_e;
    logic [CMP_W-1:0] eff_x, eff_y, eff_z;
    logic [CMP_W-1:0] x_e, y_e, z_e;

    assign size_x_e = CMP_W'(r_size_x);
    assign size_y_e = CMP_W'(r_size_y);
    assign size_z_e = CMP_W'(r_size_z);
    assign eff_x = (size_x_e > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : size_x_e;
    assign eff_y = (size_y_e > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : size_y_e;
    assign eff_z = (size_z_e > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : size_z_e;
    assign x_e = CMP_W'(r_x);
    assign y_e = CMP_W'(r_y);
    assign z_e = CMP_W'(r_z);

    // Range checks for the item and its neighbors.
    logic oor, wr_ok;
    logic xp_ok, xm_ok, yp_ok, ym_ok, zp_ok, zm_ok;

    assign oor   = (x_e >= eff_x) || (y_e >= eff_y) || (z_e >= eff_z);
    assign wr_ok = (x_e < CMP_W'(MAX_DIM)) && (y_e < CMP_W'(MAX_DIM))
                && (z_e < CMP_W'(MAX_DIM));
    assign xp_ok = (CMP_W'(x_e + 1'b1) < eff_x);
    assign yp_ok = (CMP_W'(y_e + 1'b1) < eff_y);
    assign zp_ok = (CMP_W'(z_e + 1'b1) < eff_z);
    assign xm_ok = (r_x != '0);
    assign ym_ok = (r_y != '0);
    assign zm_ok = (r_z != '0);

    // Grid indexes; a neighbor index is only used when that neighbor is valid.
    logic [CW-1:0] xi, yi, zi, xpi, xmi, ypi, ymi, zpi, zmi;

    assign xi  = CW'(r_x);
    assign yi  = CW'(r_y);
    assign zi  = CW'(r_z);
    assign xpi = xp_ok ? CW'(x_e + 1'b1) : xi;
    assign xmi = xm_ok ? CW'(x_e - 1'b1) : xi;
    assign ypi = yp_ok ? CW'(y_e + 1'b1) : yi;
    assign ymi = ym_ok ? CW'(y_e - 1'b1) : yi;
    assign zpi = zp_ok ? CW'(z_e + 1'b1) : zi;
    assign zmi = zm_ok ? CW'(z_e - 1'b1) : zi;

    // Row address for the selected row.
    logic [CW-1:0] row_y, row_z;
    logic [AW-1:0] row_addr;

    always_comb begin
        row_y = yi;
        row_z = zi;
        case (i_cmd.rd_sel)
            ROW_YP:  row_y = ypi;
            ROW_YM:  row_y = ymi;
            ROW_ZP:  row_z = zpi;
            ROW_ZM:  row_z = zmi;
            default: begin
            end
        endcase
    end

    assign row_addr = AW'(row_z) * AW'(MAX_DIM) + AW'(row_y);

    // Clearing pass counter.
    logic [AW-1:0] r_clr_cnt;
    logic          clr_last;

    assign clr_last = (r_clr_cnt == AW'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_we) begin
            r_clr_cnt <= clr_last ? '0 : r_clr_cnt + 1'b1;
        end
    end

    // Occupancy memory, single port, registered read.
    logic [MAX_DIM-1:0] r_mem [DEPTH];
    logic [MAX_DIM-1:0] r_rdata;
    logic [MAX_DIM-1:0] wb_row;

    always_comb begin
        wb_row     = r_rdata;
        wb_row[xi] = r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_we) begin
            r_mem[r_clr_cnt] <= '0;
        end else if (i_cmd.wr_back) begin
            r_mem[row_addr] <= wb_row;
        end else if (i_cmd.rd_issue) begin
            r_rdata <= r_mem[row_addr];
        end
    end

    // Remember which row the read data belongs to.
    t_row_sel r_cons_sel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) r_cons_sel <= i_cmd.rd_sel;
    end

    // Face accumulation: a face is visible when its neighbor is outside the
    // world or empty.
    logic              r_solid;
    logic [FACE_W-1:0] r_faces;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_solid <= 1'b0;
            r_faces <= '0;
        end else if (i_cmd.consume) begin
            case (r_cons_sel)
                ROW_CENTER: begin
                    r_solid          <= r_rdata[xi];
                    r_faces[FACE_PX] <= !xp_ok || !r_rdata[xpi];
                    r_faces[FACE_MX] <= !xm_ok || !r_rdata[xmi];
                end
                ROW_YP: r_faces[FACE_PY] <= !yp_ok || !r_rdata[xi];
                ROW_YM: r_faces[FACE_MY] <= !ym_ok || !r_rdata[xi];
                ROW_ZP: r_faces[FACE_PZ] <= !zp_ok || !r_rdata[xi];
                ROW_ZM: r_faces[FACE_MZ] <= !zm_ok || !r_rdata[xi];
                default: begin
                end
            endcase
        end
    end

    // Output register.
    logic              r_m_valid;
    logic [FACE_W-1:0] r_out_mask;
    logic              r_out_solid;
    logic              r_out_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out_mask  <= (r_solid && !oor) ? r_faces : '0;
            r_out_solid <= r_solid && !oor;
            r_out_oor   <= oor;
        end
    end

    assign o_m_valid      = r_m_valid;
    assign o_face_mask    = r_out_mask;
    assign o_voxel_solid  = r_out_solid;
    assign o_out_of_range = r_out_oor;

    // Status back to the controller.
    assign o_status.clear_done   = clr_last;
    assign o_status.write_ok     = wr_ok;
    assign o_status.out_of_range = oor;
    assign o_status.out_free     = !r_m_valid || i_m_ready;

endmodule

// File: hdl/vvfc_checker.sv
// ----------------------------------------------------------------------------
// Voxel face culling port checker
// Watches the top-level ports for result consistency and the one-item-at-a
// -time input behavior; bound to the top level below.
// ----------------------------------------------------------------------------
`include "voxel_visible_face_culling_unit_defines.svh"

module vvfc_checker
    import vvfc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser
);

    // A stalled result holds its value.
    `VVFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // An out-of-range result carries no faces and no occupancy.
    `VVFC_ASSERT_IMPL(a_oor_zero, m_tvalid && m_tuser, m_tdata == '0, "out-of-range result not zero")

    // A visible face implies the queried voxel is solid.
    `VVFC_ASSERT_IMPL(a_face_solid, m_tvalid && (m_tdata[5:0] != 6'd0), m_tdata[6], "faces on empty voxel")

    // After a transaction on the input the block is busy for the next cycle.
    `VVFC_ASSERT_NEXT(a_in_busy, s_tvalid && s_tready, !s_tready, "input taken back to back")

endmodule

bind voxel_visible_face_culling_unit vvfc_checker u_vvfc_checker (.*);

// File: verif/vvfc_face_checker.sv
// ----------------------------------------------------------------------------
// Voxel face culling checker
// Watches the configuration, input and result channels of the culling unit.
// It keeps its own occupancy grid and world size, works out the face mask of
// every accepted query and compares each returned result, field by field,
// with the oldest outstanding expectation.
// ----------------------------------------------------------------------------

// Codes shared by the stimulus and the checker.
package vvfc_tb_pkg;

    import vvfc_pkg::*;

    // Item kinds carried on s_tuser.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // A register index past the end of the register list.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

endpackage

module vvfc_face_checker
    import vvfc_pkg::*;
    import vvfc_tb_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration channel
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SIZE_W-1:0]      i_cfg_data,
    // Input stream
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // voxel_x, voxel_y, voxel_z, filled, pad
    input  logic                   i_s_tuser,   // action
    // Result stream
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,   // face_mask, voxel_solid, pad
    input  logic                   i_m_tuser,   // out_of_range
    // Status toward the testbench top
    output int                     o_faces_owed,
    output int                     o_mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [FACE_W-1:0] face_mask;
        logic              voxel_solid;
        logic              out_of_range;
    } t_face_result;

    // The grid starts empty, and reset is applied only once at the start.
    bit                occ_grid [0:MAX_DIM*MAX_DIM*MAX_DIM-1];
    logic [SIZE_W-1:0] size_x = SIZE_RESET;
    logic [SIZE_W-1:0] size_y = SIZE_RESET;
    logic [SIZE_W-1:0] size_z = SIZE_RESET;
    t_face_result      faces_q [$];
    int                mismatches = 0;
    int                results_seen = 0;

    function automatic int cell_addr(int x, int y, int z);
        return (z * MAX_DIM + y) * MAX_DIM + x;
    endfunction

    // Sizes beyond the grid saturate at the grid edge.
    function automatic int world_extent(logic [SIZE_W-1:0] s);
        return (int'(s) > MAX_DIM) ? MAX_DIM : int'(s);
    endfunction

    // A face is open when its neighbor lies outside the world or is empty.
    function automatic logic face_open(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0)
            return 1'b1;
        if (x >= world_extent(size_x) || y >= world_extent(size_y) ||
            z >= world_extent(size_z))
            return 1'b1;
        return !occ_grid[cell_addr(x, y, z)];
    endfunction

    function automatic t_face_result predict_visible_faces(int x, int y, int z);
        t_face_result r;
        r = '0;
        if (x >= world_extent(size_x) || y >= world_extent(size_y) ||
            z >= world_extent(size_z)) begin
            r.out_of_range = 1'b1;
            return r;
        end
        r.voxel_solid = occ_grid[cell_addr(x, y, z)];
        if (r.voxel_solid) begin
            r.face_mask[FACE_PX] = face_open(x + 1, y, z);
            r.face_mask[FACE_MX] = face_open(x - 1, y, z);
            r.face_mask[FACE_PY] = face_open(x, y + 1, z);
            r.face_mask[FACE_MY] = face_open(x, y - 1, z);
            r.face_mask[FACE_PZ] = face_open(x, y, z + 1);
            r.face_mask[FACE_MZ] = face_open(x, y, z - 1);
        end
        return r;
    endfunction

    // Everything is sampled at the rising edge, before the edge's updates land.
    always @(posedge i_clk) begin
        t_face_result       got;
        t_face_result       want;
        logic [COORD_W-1:0] vx;
        logic [COORD_W-1:0] vy;
        logic [COORD_W-1:0] vz;
        if (!i_rst_n) begin
            faces_q.delete();
            size_x = SIZE_RESET;
            size_y = SIZE_RESET;
            size_z = SIZE_RESET;
        end else begin
            // Result transaction: compare with the oldest query.
            if (i_m_tvalid && i_m_tready) begin
                got.face_mask    = i_m_tdata[FACE_W-1:0];
                got.voxel_solid  = i_m_tdata[FACE_W];
                got.out_of_range = i_m_tuser;
                results_seen++;
                if (faces_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result %0d arrived with no query outstanding: %p",
                                 $realtime, results_seen, got);
                end else begin
                    want = faces_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] result %0d: face_mask exp %b got %b, ",
                                      "voxel_solid exp %b got %b, out_of_range exp %b got %b"},
                                     $realtime, results_seen,
                                     want.face_mask, got.face_mask,
                                     want.voxel_solid, got.voxel_solid,
                                     want.out_of_range, got.out_of_range);
                    end
                end
            end

            // Register write; an index past the list changes nothing.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SIZE_X: size_x = i_cfg_data;
                    REG_SIZE_Y: size_y = i_cfg_data;
                    REG_SIZE_Z: size_z = i_cfg_data;
                    default: ;
                endcase
            end

            // Input transaction: update the grid or queue a prediction.
            if (i_s_tvalid && i_s_tready) begin
                vx = i_s_tdata[COORD_W-1:0];
                vy = i_s_tdata[2*COORD_W-1:COORD_W];
                vz = i_s_tdata[3*COORD_W-1:2*COORD_W];
                if (i_s_tuser == ACT_WRITE) begin
                    occ_grid[cell_addr(int'(vx), int'(vy), int'(vz))] =
                        i_s_tdata[3*COORD_W];
                end else begin
                    want = predict_visible_faces(int'(vx), int'(vy), int'(vz));
                    faces_q = {faces_q, want};
                end
            end
        end
        o_faces_owed     <= faces_q.size();
        o_mismatch_count <= mismatches;
    end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Voxel face culling testbench
// Drives writes and face queries into the culling unit under a series of
// world sizes, small ones and the extremes among them, with random sender
// bursts and receiver stalls. The checker beside the unit does the scoring;
// this module makes the stimulus, guards against a hang and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
    import vvfc_pkg::*;
    import vvfc_tb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT     = 20000;  // covers the clearing pass after reset
    localparam int SETTLE_CYCLES   = 12;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 137;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_BLOCK,
        RX_MOSTLY
    } t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [SIZE_W-1:0]      i_cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    int       faces_owed;
    int       mismatch_count;
    int       quiet_cycles = 0;
    int       burst_left = 0;
    int       rx_hold = 0;
    t_rx_mode rx_mode = RX_FREE;
    int       base_x;
    int       base_y;
    int       base_z;

    voxel_visible_face_culling_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    vvfc_face_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tuser        (s_tuser),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tuser        (m_tuser),
        .o_faces_owed     (faces_owed),
        .o_mismatch_count (mismatch_count)
    );

    // Clock generation.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: stretches of free flow, coin flips, hard stalls and light stalls.
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_hold = $urandom_range(1, 40);
        end
        rx_hold--;
        case (rx_mode)
            RX_FREE:  m_tready <= 1'b1;
            RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
            RX_BLOCK: m_tready <= 1'b0;
            default:  m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Watchdog: ends the run when no transaction happens for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic pause_sender(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // One input transaction, sent inside bursts of random length.
    task automatic send_item(input logic act, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                             input logic fill);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'd0, fill, z, y, x};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Waits until every query has been answered and any write has retired.
    task automatic drain_results(int settle);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (faces_owed != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    function automatic int extent_of(int s);
        return (s > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : s;
    endfunction

    // Corner of the small box that most random items fall into.
    function automatic int pick_base(int ext);
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return (ext >= 4) ? ext - 4 : 0;
            default: return $urandom_range(0, 58);
        endcase
    endfunction

    // Mostly a coordinate near the box, sometimes anywhere in the grid.
    function automatic logic [COORD_W-1:0] pick_coord(int base);
        int c;
        if ($urandom_range(0, 4) == 0)
            return COORD_W'($urandom_range(0, 63));
        c = base + $urandom_range(0, 5);
        return (c > 63) ? 6'd63 : COORD_W'(c);
    endfunction

    // Sets the world size, sometimes with a stray write past the register list.
    task automatic set_world(int sx, int sy, int sz);
        write_reg(REG_SIZE_X, SIZE_W'(sx));
        write_reg(REG_SIZE_Y, SIZE_W'(sy));
        write_reg(REG_SIZE_Z, SIZE_W'(sz));
        if ($urandom_range(0, 1) == 1)
            write_reg(REG_SPARE, SIZE_W'($urandom_range(0, 127)));
        i_cfg_valid <= 1'b0;
        base_x = pick_base(extent_of(sx));
        base_y = pick_base(extent_of(sy));
        base_z = pick_base(extent_of(sz));
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 127);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic random_items(int n);
        logic act;
        for (int i = 0; i < n; i++) begin
            act = ($urandom_range(0, 9) < 5) ? ACT_QUERY : ACT_WRITE;
            send_item(act, pick_coord(base_x), pick_coord(base_y), pick_coord(base_z),
                      ($urandom_range(0, 9) < 7));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACT_WRITE;
        m_tready    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset size: corners, hidden faces, clearing.
        send_item(ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b1);     // empty voxel, filled bit ignored
        send_item(ACT_WRITE, 6'd0, 6'd0, 6'd0, 1'b1);
        send_item(ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0);     // alone: all faces open
        send_item(ACT_WRITE, 6'd1, 6'd0, 6'd0, 1'b1);
        send_item(ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0);     // +x covered
        send_item(ACT_QUERY, 6'd1, 6'd0, 6'd0, 1'b0);     // -x covered
        send_item(ACT_WRITE, 6'd0, 6'd1, 6'd0, 1'b1);
        send_item(ACT_WRITE, 6'd0, 6'd0, 6'd1, 1'b1);
        send_item(ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0);     // only the lower faces open
        send_item(ACT_WRITE, 6'd63, 6'd63, 6'd63, 1'b1);
        send_item(ACT_QUERY, 6'd63, 6'd63, 6'd63, 1'b0);  // upper grid edge
        send_item(ACT_WRITE, 6'd63, 6'd63, 6'd62, 1'b1);
        send_item(ACT_QUERY, 6'd63, 6'd63, 6'd63, 1'b0);
        send_item(ACT_WRITE, 6'd63, 6'd62, 6'd63, 1'b1);
        send_item(ACT_QUERY, 6'd63, 6'd63, 6'd63, 1'b1);
        send_item(ACT_WRITE, 6'd1, 6'd0, 6'd0, 1'b0);     // clear a neighbor again
        send_item(ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0);
        send_item(ACT_QUERY, 6'd5, 6'd5, 6'd5, 1'b0);
        send_item(ACT_WRITE, 6'd42, 6'd21, 6'd42, 1'b1);
        send_item(ACT_QUERY, 6'd42, 6'd21, 6'd42, 1'b0);
        drain_results(SETTLE_CYCLES);

        // One-voxel world: everything around the origin lies outside.
        set_world(1, 1, 1);
        send_item(ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0);
        send_item(ACT_QUERY, 6'd1, 6'd0, 6'd0, 1'b0);     // just past the world
        send_item(ACT_QUERY, 6'd0, 6'd63, 6'd0, 1'b0);
        send_item(ACT_WRITE, 6'd1, 6'd0, 6'd0, 1'b1);     // stored outside the world
        send_item(ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0);
        random_items(ITEMS_PER_PHASE - 5);
        drain_results(SETTLE_CYCLES);

        // Fixed sizes first, extremes among them, then random ones.
        for (int phase = 0; phase < NUM_PHASES - 1; phase++) begin
            case (phase)
                0:       set_world(5, 4, 6);
                1:       set_world(0, 64, 64);
                2:       set_world(127, 127, 127);
                3:       set_world(64, 2, 65);
                4:       set_world(2, 127, 1);
                default: set_world(pick_size(), pick_size(), pick_size());
            endcase
            random_items(ITEMS_PER_PHASE);
            drain_results(SETTLE_CYCLES);
        end

        drain_results(20);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
